/* hdl/music_command_stream_player_core_macros.svh */
// Assertion macros shared by the checker of the music command stream player core.
`ifndef MUSIC_COMMAND_STREAM_PLAYER_CORE_MACROS_SVH
`define MUSIC_COMMAND_STREAM_PLAYER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define MCSP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define MCSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/mcsp_pkg.sv */
// Types and constants of the music command stream player.
`timescale 1ns / 1ps
`default_nettype none
package mcsp_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_START = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PSG     = 3'd1,
      EV_FM      = 3'd2,
      EV_SEEK    = 3'd3,
      EV_END     = 3'd4,
      EV_REFUSED = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      PH_CMD      = 3'd0,
      PH_PSG_DATA = 3'd1,
      PH_FM_ADDR  = 3'd2,
      PH_FM_DATA  = 3'd3,
      PH_EXT_LEN  = 3'd4,
      PH_SKIP     = 3'd5
   } phase_type;

   localparam logic [1:0] CSR_LOOP_POINT = 2'd0;
   localparam logic [1:0] CSR_FM_ENABLE  = 2'd1;
   localparam logic [1:0] CSR_PSG_ENABLE = 2'd2;

   localparam logic [7:0] OP_EXTENSION = 8'h40;
   localparam logic [7:0] OP_END       = 8'h80;
   localparam logic [7:0] LOOPS_FOREVER = 8'hFF;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] stream_byte;
      logic [7:0] repeat_count;
      logic       repeat_forever;
   } item_type;

   typedef struct packed {
      logic [23:0] loop_point;
      logic        fm_enable;
      logic        psg_enable;
   } cfg_type;

   typedef struct packed {
      logic       play_active;
      logic [6:0] delay_left;
      logic [7:0] loops_left;
      logic       loop_forever;
      phase_type  phase;
      logic [5:0] pairs_left;
      logic [5:0] skip_left;
      logic [7:0] held_address;
   } state_type;

   typedef struct packed {
      event_type   event_kind;
      logic [7:0]  reg_address;
      logic [7:0]  reg_data;
      logic [23:0] seek_offset;
      logic        playing;
      logic        wants_bytes;
   } rsp_type;

endpackage
`default_nettype wire

/* hdl/mcsp_step.sv */
// Combinational step: parser phase, player state update and result of one item.
`timescale 1ns / 1ps
`default_nettype none
module mcsp_step (
   input  mcsp_pkg::item_type  item,
   input  mcsp_pkg::cfg_type   cfg,
   input  mcsp_pkg::state_type st,
   output mcsp_pkg::state_type st_next,
   output mcsp_pkg::rsp_type   rsp
);
   import mcsp_pkg::*;

   logic       byte_taken;
   phase_type  phase_next;
   logic [7:0] b;
   logic [7:0] loops_dec;

   assign b          = item.stream_byte;
   assign byte_taken = (item.command == CMD_BYTE) && st.play_active && (st.delay_left == 7'd0);
   assign loops_dec  = st.loops_left - 8'd1;

   // next parser phase
   always_comb begin
      phase_next = st.phase;
      if (item.command == CMD_START) begin
         phase_next = PH_CMD;
      end else if (byte_taken) begin
         unique case (st.phase)
            PH_PSG_DATA: phase_next = PH_CMD;
            PH_FM_ADDR:  phase_next = PH_FM_DATA;
            PH_FM_DATA:  phase_next = (st.pairs_left == 6'd1) ? PH_CMD : PH_FM_ADDR;
            PH_EXT_LEN:  phase_next = (b[5:0] != 6'd0) ? PH_SKIP : PH_CMD;
            PH_SKIP:     phase_next = (st.skip_left == 6'd1) ? PH_CMD : PH_SKIP;
            default: begin
               if (b[7:6] == 2'b00) begin
                  phase_next = PH_PSG_DATA;
               end else if (b == OP_EXTENSION) begin
                  phase_next = PH_EXT_LEN;
               end else if (b[7:6] == 2'b01) begin
                  phase_next = (b[5:0] != 6'd0) ? PH_FM_ADDR : PH_CMD;
               end else begin
                  phase_next = PH_CMD;
               end
            end
         endcase
      end
   end

   // counters, result fields
   always_comb begin
      st_next         = st;
      rsp             = '0;
      rsp.event_kind  = EV_NONE;
      unique case (item.command)
         CMD_TICK: begin
            if (st.play_active && (st.delay_left != 7'd0)) begin
               st_next.delay_left = st.delay_left - 7'd1;
            end
         end
         CMD_BYTE: begin
            if (!byte_taken) begin
               rsp.event_kind = EV_REFUSED;
            end else begin
               unique case (st.phase)
                  PH_PSG_DATA: begin
                     if (cfg.psg_enable) begin
                        rsp.event_kind  = EV_PSG;
                        rsp.reg_address = st.held_address;
                        rsp.reg_data    = b;
                     end
                  end
                  PH_FM_ADDR: st_next.held_address = b;
                  PH_FM_DATA: begin
                     if (cfg.fm_enable) begin
                        rsp.event_kind  = EV_FM;
                        rsp.reg_address = st.held_address;
                        rsp.reg_data    = b;
                     end
                     st_next.pairs_left = st.pairs_left - 6'd1;
                  end
                  PH_EXT_LEN: st_next.skip_left = b[5:0];
                  PH_SKIP:    st_next.skip_left = st.skip_left - 6'd1;
                  default: begin
                     if (b[7:6] == 2'b00) begin
                        st_next.held_address = {2'b00, b[5:0]};
                     end else if (b == OP_EXTENSION) begin
                        st_next.held_address = st.held_address;
                     end else if (b[7:6] == 2'b01) begin
                        st_next.pairs_left = b[5:0];
                     end else if (b == OP_END) begin
                        if ((st.loops_left != 8'd0) && (cfg.loop_point != 24'd0)) begin
                           rsp.event_kind  = EV_SEEK;
                           rsp.seek_offset = cfg.loop_point;
                           st_next.loops_left = (st.loop_forever && (loops_dec == 8'd0)) ?
                                                LOOPS_FOREVER : loops_dec;
                        end else begin
                           rsp.event_kind      = EV_END;
                           st_next.play_active = 1'b0;
                           st_next.delay_left  = 7'd0;
                        end
                     end else begin
                        st_next.delay_left = b[6:0];
                     end
                  end
               endcase
            end
         end
         CMD_START: begin
            st_next.delay_left   = 7'd1;
            st_next.play_active  = 1'b1;
            st_next.loop_forever = item.repeat_forever;
            st_next.loops_left   = item.repeat_forever ? LOOPS_FOREVER : item.repeat_count;
            st_next.pairs_left   = 6'd0;
            st_next.skip_left    = 6'd0;
         end
         default: st_next.play_active = 1'b0;
      endcase
      st_next.phase   = phase_next;
      rsp.playing     = st_next.play_active;
      rsp.wants_bytes = st_next.play_active && (st_next.delay_left == 7'd0);
   end

endmodule
`default_nettype wire

/* hdl/mcsp_rsp_reg.sv */
// Result register with valid flag; frees itself when the consumer takes the transfer.
`timescale 1ns / 1ps
`default_nettype none
module mcsp_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mcsp_pkg::rsp_type rsp_next,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output mcsp_pkg::rsp_type rsp,
   output logic              free
);
   import mcsp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);
   assign data_in  = load ? rsp_next : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule
`default_nettype wire

/* hdl/music_command_stream_player_core.sv */
// Top level of the music command stream player core.
// Takes one item per clock while the result consumer does not stall: an
// accepted item is parsed from the input register after its transfer and,
// once the result register is free, applied to the player state at the
// edge where its single result is registered. Both register stages hold
// while the result consumer stalls. Configuration writes take effect at once
// and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none
module music_command_stream_player_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_stream_byte,
   input  logic [7:0]  req_repeat_count,
   input  logic        req_repeat_forever,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_reg_address,
   output logic [7:0]  rsp_reg_data,
   output logic [23:0] rsp_seek_offset,
   output logic        rsp_playing,
   output logic        rsp_wants_bytes,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data
);
   import mcsp_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   item_type  item_ff;
   item_type  item_in;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   state_type state_next;
   rsp_type   rsp_next;
   rsp_type   rsp_q;
   logic      out_free;
   logic      advance;
   logic      req_transfer;

   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || advance;
   assign req_transfer = req_valid && req_ready;
   assign in_valid_in  = req_transfer || (in_valid_ff && !advance);
   assign item_in      = req_transfer ?
                         item_type'{command:        cmd_type'(req_command),
                                    stream_byte:    req_stream_byte,
                                    repeat_count:   req_repeat_count,
                                    repeat_forever: req_repeat_forever} : item_ff;
   assign state_in     = advance ? state_next : state_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOOP_POINT: cfg_in.loop_point = csr_write_data;
            CSR_FM_ENABLE:  cfg_in.fm_enable  = csr_write_data[0];
            CSR_PSG_ENABLE: cfg_in.psg_enable = csr_write_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cfg_ff      <= '0;
         state_ff    <= '{play_active: 1'b0, delay_left: 7'd0, loops_left: 8'd0,
                          loop_forever: 1'b0, phase: PH_CMD, pairs_left: 6'd0,
                          skip_left: 6'd0, held_address: 8'd0};
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   mcsp_step u_step (
      .item    (item_ff),
      .cfg     (cfg_ff),
      .st      (state_ff),
      .st_next (state_next),
      .rsp     (rsp_next)
   );

   mcsp_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .rsp_next  (rsp_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_q),
      .free      (out_free)
   );

   assign rsp_event_kind  = rsp_q.event_kind;
   assign rsp_reg_address = rsp_q.reg_address;
   assign rsp_reg_data    = rsp_q.reg_data;
   assign rsp_seek_offset = rsp_q.seek_offset;
   assign rsp_playing     = rsp_q.playing;
   assign rsp_wants_bytes = rsp_q.wants_bytes;

endmodule
`default_nettype wire

/* hdl/mcsp_checker.sv */
// Port-level checker for the music command stream player core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "music_command_stream_player_core_macros.svh"
module mcsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_kind,
   input logic [23:0] rsp_seek_offset,
   input logic        rsp_playing,
   input logic        rsp_wants_bytes
);
   import mcsp_pkg::*;

   `MCSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_kind) && $stable(rsp_seek_offset), "stalled result transfer changed")
   `MCSP_ASSERT_IMPLY(a_wants_needs_play, rsp_valid && rsp_wants_bytes, rsp_playing, "wants bytes while not playing")
   `MCSP_ASSERT_IMPLY(a_write_keeps_stream, rsp_valid && (rsp_event_kind == EV_PSG || rsp_event_kind == EV_FM), rsp_playing && rsp_wants_bytes, "write event without stream open")
   `MCSP_ASSERT_IMPLY(a_end_stops, rsp_valid && rsp_event_kind == EV_END, !rsp_playing && !rsp_wants_bytes, "playback ended but still playing")
   `MCSP_ASSERT_IMPLY(a_seek_offset, rsp_valid && rsp_event_kind == EV_SEEK, rsp_playing && rsp_seek_offset != 24'd0, "seek without loop point")

endmodule

bind music_command_stream_player_core mcsp_checker u_mcsp_checker (.*);
`default_nettype wire
